[sv/hkrb_pkg.sv]
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types and constants of the keyboard report builder: status codes,
// controller states and the command/flag groups between control and datapath.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    localparam int unsigned NUM_CODES    = 256;
    localparam int unsigned REPORT_SLOTS = 30;
    localparam logic [7:0]  MOD_FIRST    = 8'hE0;
    localparam logic [7:0]  MOD_LAST     = 8'hE7;
    localparam logic [7:0]  COUNT_MAX    = 8'hFF;

    typedef enum logic [2:0] {
        ST_CHANGED    = 3'd0,
        ST_COUNT_ONLY = 3'd1,
        ST_SATURATED  = 3'd2,
        ST_UNPRESSED  = 3'd3,
        ST_MOD_SAME   = 3'd4,
        ST_FULL       = 3'd5,
        ST_NOT_FOUND  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    load_in;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    mod_write;
        logic    append;
        logic    search_start;
        logic    search_step;
        logic    remove;
        logic    set_status;
        status_t status;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic press;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_max;
        logic is_mod;
        logic mod_same;
        logic list_full;
        logic search_end;
        logic match;
        logic out_free;
    } dp_flags_t;

endpackage

[sv/hkrb_ram.sv]
// ----------------------------------------------------------------------------
// hkrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hkrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/hkrb_datapath.sv]
// ----------------------------------------------------------------------------
// hkrb_datapath
// Press counters, modifier byte, ordered key list with search pointer and
// shift-down removal, batch tracking and the result output register.
// ----------------------------------------------------------------------------
module hkrb_datapath #(
    parameter int KEY_SLOTS = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        key_code,
    input  logic              req_type,
    input  logic              batch_last,
    input  logic              out_ready,
    input  hkrb_pkg::dp_cmd_t cmd,
    output hkrb_pkg::dp_flags_t flags,
    output logic              out_valid,
    output logic [2:0]        status,
    output logic              report_changed,
    output logic [7:0]        modifiers,
    output logic [63:0]       keys_low,
    output logic [63:0]       keys_mid,
    output logic [63:0]       keys_high,
    output logic [47:0]       keys_top,
    output logic [4:0]        held_keys
);
    import hkrb_pkg::*;

    localparam int CNT_W = $clog2(KEY_SLOTS + 1);
    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int ADR_W = $clog2(NUM_CODES);

    // captured event
    logic [7:0]           code_reg;
    logic                 press_reg;
    logic                 last_reg;

    // press counter storage
    logic [NUM_CODES-1:0] valid_bits_reg;
    logic [NUM_CODES-1:0] valid_bits_next;
    logic                 valid_rd_reg;
    logic [7:0]           ram_rdata;
    logic [7:0]           cnt;
    logic [7:0]           cnt_new;
    logic                 cnt_we;

    // report state
    logic [7:0]           modifier_reg;
    logic [7:0]           modifier_next;
    logic [7:0]           slot_reg  [KEY_SLOTS];
    logic [7:0]           slot_next [KEY_SLOTS];
    logic [CNT_W-1:0]     slot_count_reg;
    logic [CNT_W-1:0]     slot_count_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic [7:0]           slot_rd;
    logic [8*REPORT_SLOTS-1:0] slots_flat;

    // result
    status_t              status_reg;
    logic                 batch_dirty_reg;
    logic                 dirty_any;
    logic                 out_valid_reg;
    logic [2:0]           status_out_reg;
    logic                 changed_out_reg;
    logic [7:0]           mod_out_reg;
    logic [8*REPORT_SLOTS-1:0] keys_out_reg;
    logic [4:0]           held_out_reg;

    // capture the accepted event
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            code_reg  <= key_code;
            press_reg <= req_type;
            last_reg  <= batch_last;
        end
    end

    // count memory: a code never written reads as zero through its valid bit
    hkrb_ram #(
        .WIDTH (8),
        .DEPTH (NUM_CODES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (code_reg[ADR_W-1:0]),
        .wdata (cnt_new),
        .re    (cmd.load_in),
        .raddr (key_code[ADR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign cnt     = valid_rd_reg ? ram_rdata : 8'd0;
    assign cnt_we  = cmd.cnt_inc | cmd.cnt_dec;
    assign cnt_new = cmd.cnt_inc ? (cnt + 8'd1) : (cnt - 8'd1);

    always_comb
    begin
        valid_bits_next = valid_bits_reg;
        if (cnt_we)
        begin
            valid_bits_next[code_reg[ADR_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            valid_rd_reg   <= 1'b0;
        end
        else
        begin
            valid_bits_reg <= valid_bits_next;
            if (cmd.load_in)
            begin
                valid_rd_reg <= valid_bits_reg[key_code[ADR_W-1:0]];
            end
        end
    end

    // modifier byte: write the pressed state into the addressed bit
    always_comb
    begin
        modifier_next = modifier_reg;
        if (cmd.mod_write)
        begin
            modifier_next[code_reg[2:0]] = press_reg;
        end
    end

    // key list: append at the fill point, shift down from the found slot
    for (genvar j = 0; j < KEY_SLOTS; j++)
    begin : g_slot
        always_comb
        begin
            slot_next[j] = slot_reg[j];
            if (cmd.append && (CNT_W'(j) == slot_count_reg))
            begin
                slot_next[j] = code_reg;
            end
            if (cmd.remove && (CNT_W'(j) >= idx_reg))
            begin
                if (j + 1 < KEY_SLOTS)
                begin
                    slot_next[j] = slot_reg[(j + 1) % KEY_SLOTS];
                end
                else
                begin
                    slot_next[j] = 8'd0;
                end
            end
        end
    end

    always_comb
    begin
        slot_count_next = slot_count_reg;
        if (cmd.append)
        begin
            slot_count_next = slot_count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            slot_count_next = slot_count_reg - CNT_W'(1);
        end
    end

    // search pointer walks one slot per cycle while search_step is set
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.search_start)
        begin
            idx_next = '0;
        end
        else if (cmd.search_step)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    assign slot_rd = slot_reg[idx_reg[IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg   <= '0;
            slot_count_reg <= '0;
            idx_reg        <= '0;
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                slot_reg[k] <= '0;
            end
        end
        else
        begin
            modifier_reg   <= modifier_next;
            slot_count_reg <= slot_count_next;
            idx_reg        <= idx_next;
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                slot_reg[k] <= slot_next[k];
            end
        end
    end

    // hold the status of the current event
    always_ff @(posedge clk)
    begin
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
    end

    // flags for the controller
    always_comb
    begin
        flags.press      = press_reg;
        flags.cnt_zero   = (cnt == 8'd0);
        flags.cnt_one    = (cnt == 8'd1);
        flags.cnt_max    = (cnt == COUNT_MAX);
        flags.is_mod     = (code_reg >= MOD_FIRST) && (code_reg <= MOD_LAST);
        flags.mod_same   = (modifier_reg[code_reg[2:0]] == press_reg);
        flags.list_full  = (slot_count_reg >= CNT_W'(KEY_SLOTS));
        flags.search_end = (idx_reg >= slot_count_reg);
        flags.match      = !flags.search_end && (slot_rd == code_reg);
        flags.out_free   = !out_valid_reg || out_ready;
    end

    // flatten the list for the report, unused slots read as zero
    for (genvar k = 0; k < REPORT_SLOTS; k++)
    begin : g_flat
        if (k < KEY_SLOTS)
        begin : g_used
            assign slots_flat[8*k +: 8] = slot_reg[k];
        end
        else
        begin : g_unused
            assign slots_flat[8*k +: 8] = 8'd0;
        end
    end

    assign dirty_any = batch_dirty_reg || (status_reg == ST_CHANGED);

    // batch tracking and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_dirty_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                batch_dirty_reg <= last_reg ? 1'b0 : dirty_any;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_out_reg  <= status_reg;
            changed_out_reg <= last_reg && dirty_any;
            mod_out_reg     <= modifier_reg;
            keys_out_reg    <= slots_flat;
            held_out_reg    <= 5'(slot_count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign report_changed = changed_out_reg;
    assign modifiers      = mod_out_reg;
    assign keys_low       = keys_out_reg[63:0];
    assign keys_mid       = keys_out_reg[127:64];
    assign keys_high      = keys_out_reg[191:128];
    assign keys_top       = keys_out_reg[239:192];
    assign held_keys      = held_out_reg;

endmodule

[sv/hkrb_ctrl.sv]
// ----------------------------------------------------------------------------
// hkrb_ctrl
// Controller: accepts one event, decides the count and report action from
// the datapath flags, walks the list search and hands over the result.
// ----------------------------------------------------------------------------
module hkrb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hkrb_pkg::dp_flags_t flags,
    output hkrb_pkg::dp_cmd_t   cmd
);
    import hkrb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_CHANGED;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
                if (flags.press)
                begin
                    if (flags.cnt_max)
                    begin
                        cmd.status = ST_SATURATED;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        if (!flags.cnt_zero)
                        begin
                            cmd.status = ST_COUNT_ONLY;
                        end
                        else if (flags.is_mod)
                        begin
                            cmd.mod_write = 1'b1;
                            cmd.status    = flags.mod_same ? ST_MOD_SAME : ST_CHANGED;
                        end
                        else if (flags.list_full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cmd.status = ST_CHANGED;
                        end
                    end
                end
                else
                begin
                    if (flags.cnt_zero)
                    begin
                        cmd.status = ST_UNPRESSED;
                    end
                    else
                    begin
                        cmd.cnt_dec = 1'b1;
                        if (!flags.cnt_one)
                        begin
                            cmd.status = ST_COUNT_ONLY;
                        end
                        else if (flags.is_mod)
                        begin
                            cmd.mod_write = 1'b1;
                            cmd.status    = flags.mod_same ? ST_MOD_SAME : ST_CHANGED;
                        end
                        else
                        begin
                            // last release of a list key: go find it
                            cmd.set_status   = 1'b0;
                            cmd.search_start = 1'b1;
                            state_next       = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (flags.search_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else if (flags.match)
                begin
                    cmd.remove     = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_CHANGED;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                cmd.load_out = flags.out_free;
                if (flags.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/hid_keyboard_report_builder_top.sv]
// Flow: an event is accepted in S_IDLE, decided in S_READ and handed
//   from S_DONE to the output register; a last release of a list key first
//   walks S_SEARCH, a serial search over the key list, one slot a cycle.
// Events are taken one at a time: a waiting result holds S_DONE, and
//   the next transaction is not accepted until it is handed over.
// Reset: counters read as zero at once through per-code valid bits, no
//   clearing pass; list, modifiers and batch state clear immediately.
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_top
// Keyboard report builder: per-code press counts, modifier byte and an
// ordered rollover key list, one status and report per key event.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_top #(
    parameter int KEY_SLOTS = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  key_code,
    input  logic        req_type,
    input  logic        batch_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        report_changed,
    output logic [7:0]  modifiers,
    output logic [63:0] keys_low,
    output logic [63:0] keys_mid,
    output logic [63:0] keys_high,
    output logic [47:0] keys_top,
    output logic [4:0]  held_keys
);
    import hkrb_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    // controller
    hkrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (flags),
        .cmd      (cmd)
    );

    // datapath
    hkrb_datapath #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_code       (key_code),
        .req_type       (req_type),
        .batch_last     (batch_last),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .flags          (flags),
        .out_valid      (out_valid),
        .status         (status),
        .report_changed (report_changed),
        .modifiers      (modifiers),
        .keys_low       (keys_low),
        .keys_mid       (keys_mid),
        .keys_high      (keys_high),
        .keys_top       (keys_top),
        .held_keys      (held_keys)
    );

    // one event at a time: no new transaction right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("transaction accepted while previous event in progress");

    // append only below capacity
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !flags.list_full)
        else $error("append into a full key list");

    // removal only at a slot inside the occupied part of the list
    a_remove_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |-> (!flags.search_end && flags.match))
        else $error("removal outside the occupied list");

    // reported key count never exceeds the list size
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_keys <= 5'(KEY_SLOTS)))
        else $error("held key count beyond list size");

endmodule
